[sv/chained_hash_table_engine_assert.svh]
`ifndef CHAINED_HASH_TABLE_ENGINE_ASSERT_SVH
`define CHAINED_HASH_TABLE_ENGINE_ASSERT_SVH
// Same-cycle implication, sampled at every rising edge outside reset.
`define CHTE_CHECK(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chte: same-cycle check failed");
// Next-cycle implication, sampled at every rising edge outside reset.
`define CHTE_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chte: next-cycle check failed");
`endif

[sv/chte_pkg.sv]
`timescale 1ns / 1ps
package chte_pkg;

    localparam int KEY_W       = 64;
    localparam int VAL_W       = 64;
    localparam int COUNT_W     = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 4;
    localparam int STATUS_W    = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    localparam logic [CFG_IDX_W-1:0]  REG_KEY_BYTES   = 1'b0;
    localparam logic [CFG_IDX_W-1:0]  REG_VALUE_BYTES = 1'b1;
    localparam logic [CFG_DATA_W-1:0] BYTES_RESET     = 4'd8;

    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_SET = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_UPDATED  = 3'd2,
        ST_INSERTED = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_HASH,
        FS_MOD,
        FS_PUSH
    } fe_state_t;

    typedef enum logic [1:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_EXEC
    } be_state_t;

    // Byte counts already clamped to 1..8
    typedef struct packed {
        logic [CFG_DATA_W-1:0] key_bytes;
        logic [CFG_DATA_W-1:0] value_bytes;
    } cfg_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } req_t;

    localparam int REQ_W = $bits(req_t);

    function automatic logic [CFG_DATA_W-1:0] clamp_bytes(input logic [CFG_DATA_W-1:0] n);
        logic [CFG_DATA_W-1:0] r;
        r = n;
        if (n == '0) begin
            r = 4'd1;
        end
        else if (n > 4'd8) begin
            r = 4'd8;
        end
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] byte_mask(input logic [CFG_DATA_W-1:0] n);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < n) begin
                m[i*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    // One sdbm round: h * 65599 plus the sign-extended byte, wrapping at 64 bits
    function automatic logic [KEY_W-1:0] sdbm_step(input logic [KEY_W-1:0] h,
                                                   input logic [7:0] b);
        logic [KEY_W-1:0] bx;
        bx = {{(KEY_W-8){b[7]}}, b};
        return bx + (h << 6) + (h << 16) - h;
    endfunction

endpackage

[sv/chte_queue.sv]
`timescale 1ns / 1ps
module chte_queue #(
    parameter int W = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         full,
    output logic         empty
);
    import chte_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]      slot_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_mem[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = slot_mem[rd_ptr_reg];
    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

endmodule

[sv/chte_front.sv]
`timescale 1ns / 1ps
`include "chained_hash_table_engine_assert.svh"
module chte_front #(
    parameter int BUCKETS = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic                                        cmd,
    input  logic [chte_pkg::KEY_W-1:0]                  key,
    input  logic [chte_pkg::VAL_W-1:0]                  value,
    input  chte_pkg::cfg_t                              cfg,
    input  logic                                        clear_done,
    input  logic                                        q_full,
    output logic                                        push,
    output logic [$clog2(BUCKETS)+chte_pkg::REQ_W-1:0]  q_wdata
);
    import chte_pkg::*;

    localparam int BW = $clog2(BUCKETS);
    localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
    // Reciprocal of BUCKETS: for any XW-bit x, x * RECIP >> SH is exactly x / BUCKETS
    localparam int XW = BW + 8;
    localparam int RW = XW + 1;
    localparam int PW = XW + RW;
    localparam int SH = XW + BW;
    localparam logic [RW-1:0] RECIP = RW'(((64'd1 << SH) + 64'(BUCKETS - 1)) / 64'(BUCKETS));

    fe_state_t             fe_state_reg, fe_state_next;
    req_t                  req_reg, req_next;
    logic [KEY_W-1:0]      shift_reg, shift_next;
    logic [KEY_W-1:0]      hash_reg, hash_next;
    logic [2:0]            cnt_reg, cnt_next;
    logic [CFG_DATA_W-1:0] nbytes_reg, nbytes_next;
    logic [BW-1:0]         rem_reg, rem_next;
    logic                  accept;
    logic [BW-1:0]         bucket;

    // Remainder of (r * 256 + byte) by BUCKETS via reciprocal multiply
    function automatic logic [BW-1:0] mod_byte(input logic [BW-1:0] r_in,
                                               input logic [7:0] bits);
        logic [XW-1:0] x;
        logic [PW-1:0] prod;
        logic [7:0]    q;
        logic [XW-1:0] t;
        x    = {r_in, bits};
        prod = PW'(x) * PW'(RECIP);
        q    = prod[SH +: 8];
        t    = x - XW'(q) * XW'(BUCKETS);
        return t[BW-1:0];
    endfunction

    always_comb
    begin
        fe_state_next = fe_state_reg;
        req_next      = req_reg;
        shift_next    = shift_reg;
        hash_next     = hash_reg;
        cnt_next      = cnt_reg;
        nbytes_next   = nbytes_reg;
        rem_next      = rem_reg;
        in_ready      = (fe_state_reg == FS_IDLE) && clear_done;
        accept        = in_valid && in_ready;
        push          = 1'b0;
        case (fe_state_reg)
            FS_IDLE:
            begin
                if (accept)
                begin
                    req_next.cmd   = cmd_t'(cmd);
                    req_next.key   = key & byte_mask(cfg.key_bytes);
                    req_next.value = value & byte_mask(cfg.value_bytes);
                    shift_next     = key;
                    hash_next      = '0;
                    cnt_next       = '0;
                    nbytes_next    = cfg.key_bytes;
                    rem_next       = '0;
                    fe_state_next  = FS_HASH;
                end
            end
            FS_HASH:
            begin
                // one key byte per cycle, lowest first
                hash_next  = sdbm_step(hash_reg, shift_reg[7:0]);
                shift_next = shift_reg >> 8;
                cnt_next   = cnt_reg + 3'd1;
                if (4'(cnt_reg) == nbytes_reg - 4'd1)
                begin
                    cnt_next      = '0;
                    fe_state_next = POW2 ? FS_PUSH : FS_MOD;
                end
            end
            FS_MOD:
            begin
                // fold the hash into the remainder one byte per cycle
                rem_next  = mod_byte(rem_reg, hash_reg[KEY_W-1 -: 8]);
                hash_next = hash_reg << 8;
                cnt_next  = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    fe_state_next = FS_PUSH;
                end
            end
            FS_PUSH:
            begin
                if (!q_full)
                begin
                    push          = 1'b1;
                    fe_state_next = FS_IDLE;
                end
            end
            default:
            begin
                fe_state_next = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fe_state_reg <= FS_IDLE;
        end
        else
        begin
            fe_state_reg <= fe_state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        shift_reg  <= shift_next;
        hash_reg   <= hash_next;
        cnt_reg    <= cnt_next;
        nbytes_reg <= nbytes_next;
        rem_reg    <= rem_next;
    end

    assign bucket  = POW2 ? hash_reg[BW-1:0] : rem_reg;
    assign q_wdata = {bucket, req_reg};

    `CHTE_CHECK(a_push_room, push, !q_full)
    `CHTE_CHECK(a_hash_count, fe_state_reg == FS_HASH, 4'(cnt_reg) < nbytes_reg)

endmodule

[sv/chte_back.sv]
`timescale 1ns / 1ps
`include "chained_hash_table_engine_assert.svh"
module chte_back #(
    parameter int BUCKETS = 16,
    parameter int WAYS    = 4
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        q_empty,
    input  logic [$clog2(BUCKETS)+chte_pkg::REQ_W-1:0]  q_rdata,
    output logic                                        pop,
    input  chte_pkg::cfg_t                              cfg,
    output logic                                        clear_done,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic [chte_pkg::STATUS_W-1:0]               status,
    output logic [chte_pkg::VAL_W-1:0]                  value_out,
    output logic [chte_pkg::COUNT_W-1:0]                entry_count
);
    import chte_pkg::*;

    localparam int BW    = $clog2(BUCKETS);
    localparam int LW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FW    = $clog2(WAYS + 1);
    localparam int KROW_W = WAYS * KEY_W;
    localparam int VROW_W = WAYS * VAL_W;

    // bucket rows: all ways of one bucket side by side
    logic [KROW_W-1:0] key_mem  [BUCKETS];
    logic [VROW_W-1:0] val_mem  [BUCKETS];
    logic [FW-1:0]     fill_mem [BUCKETS];

    be_state_t          be_state_reg, be_state_next;
    req_t               cur_req_reg;
    logic [BW-1:0]      cur_bucket_reg;
    logic [KROW_W-1:0]  key_row_reg;
    logic [VROW_W-1:0]  val_row_reg;
    logic [FW-1:0]      fill_rd_reg;
    logic [BW-1:0]      clear_cnt_reg, clear_cnt_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic               out_valid_reg, out_valid_next;
    status_t            status_reg;
    logic [VAL_W-1:0]   value_out_reg;
    logic [COUNT_W-1:0] entry_count_reg;

    logic               rd_en;
    logic               done;
    logic               out_free;
    logic               clearing;
    logic [BW-1:0]      rd_bucket;
    logic [KEY_W-1:0]   kmask;
    logic [VAL_W-1:0]   vmask;
    logic               found;
    logic [LW-1:0]      slot;
    logic [LW-1:0]      lane;
    logic               is_full;
    logic               do_insert;
    logic               do_update;
    logic [VAL_W-1:0]   hit_value;
    status_t            status_now;
    logic [KROW_W-1:0]  key_wrow;
    logic [VROW_W-1:0]  val_wrow;
    logic               fill_we;
    logic [BW-1:0]      fill_waddr;
    logic [FW-1:0]      fill_wdata;

    assign rd_bucket = q_rdata[REQ_W +: BW];
    assign out_free  = !out_valid_reg || out_ready;
    assign clearing  = (be_state_reg == BS_CLEAR);

    // match, pick and merge on the registered bucket row
    always_comb
    begin
        kmask = byte_mask(cfg.key_bytes);
        vmask = byte_mask(cfg.value_bytes);
        found = 1'b0;
        slot  = '0;
        // lowest matching way wins
        for (int w = WAYS - 1; w >= 0; w--) begin
            if ((FW'(w) < fill_rd_reg) &&
                (((key_row_reg[w*KEY_W +: KEY_W] ^ cur_req_reg.key) & kmask) == '0))
            begin
                found = 1'b1;
                slot  = LW'(w);
            end
        end
        hit_value = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (LW'(w) == slot)
            begin
                hit_value = val_row_reg[w*VAL_W +: VAL_W];
            end
        end
        is_full   = (fill_rd_reg == FW'(WAYS));
        lane      = found ? slot : fill_rd_reg[LW-1:0];
        do_update = (cur_req_reg.cmd == CMD_SET) && found;
        do_insert = (cur_req_reg.cmd == CMD_SET) && !found && !is_full;
        for (int w = 0; w < WAYS; w++) begin
            key_wrow[w*KEY_W +: KEY_W] = (LW'(w) == lane) ? cur_req_reg.key
                                                          : key_row_reg[w*KEY_W +: KEY_W];
            val_wrow[w*VAL_W +: VAL_W] = (LW'(w) == lane) ? cur_req_reg.value
                                                          : val_row_reg[w*VAL_W +: VAL_W];
        end
        if (cur_req_reg.cmd == CMD_GET)
        begin
            status_now = found ? ST_HIT : ST_MISS;
        end
        else if (found)
        begin
            status_now = ST_UPDATED;
        end
        else if (is_full)
        begin
            status_now = ST_FULL;
        end
        else
        begin
            status_now = ST_INSERTED;
        end
    end

    always_comb
    begin
        be_state_next = be_state_reg;
        pop           = 1'b0;
        rd_en         = 1'b0;
        done          = 1'b0;
        clear_done    = (be_state_reg != BS_CLEAR);
        case (be_state_reg)
            BS_CLEAR:
            begin
                if (clear_cnt_reg == BW'(BUCKETS - 1))
                begin
                    be_state_next = BS_IDLE;
                end
            end
            BS_IDLE:
            begin
                if (!q_empty)
                begin
                    pop           = 1'b1;
                    rd_en         = 1'b1;
                    be_state_next = BS_EXEC;
                end
            end
            BS_EXEC:
            begin
                if (out_free)
                begin
                    done          = 1'b1;
                    be_state_next = BS_IDLE;
                end
            end
            default:
            begin
                be_state_next = BS_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        clear_cnt_next = clearing ? clear_cnt_reg + 1'b1 : clear_cnt_reg;
        total_next     = total_reg + COUNT_W'(done && do_insert);
        out_valid_next = out_valid_reg;
        if (done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        fill_we    = clearing || (done && do_insert);
        fill_waddr = clearing ? clear_cnt_reg : cur_bucket_reg;
        fill_wdata = clearing ? '0 : fill_rd_reg + FW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            be_state_reg <= BS_CLEAR;
        end
        else
        begin
            be_state_reg <= be_state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clear_cnt_reg <= clear_cnt_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done && do_insert)
        begin
            key_mem[cur_bucket_reg] <= key_wrow;
        end
        if (rd_en)
        begin
            key_row_reg <= key_mem[rd_bucket];
        end
    end

    always_ff @(posedge clk)
    begin
        if (done && (do_insert || do_update))
        begin
            val_mem[cur_bucket_reg] <= val_wrow;
        end
        if (rd_en)
        begin
            val_row_reg <= val_mem[rd_bucket];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        if (rd_en)
        begin
            fill_rd_reg <= fill_mem[rd_bucket];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_req_reg    <= req_t'(q_rdata[REQ_W-1:0]);
            cur_bucket_reg <= rd_bucket;
        end
        if (done)
        begin
            status_reg      <= status_now;
            value_out_reg   <= (status_now == ST_HIT) ? (hit_value & vmask) : '0;
            entry_count_reg <= total_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign value_out   = value_out_reg;
    assign entry_count = entry_count_reg;

    `CHTE_CHECK(a_fill_bound, be_state_reg == BS_EXEC, fill_rd_reg <= FW'(WAYS))
    `CHTE_CHECK(a_zero_on_miss, out_valid_reg && (status_reg != ST_HIT), value_out_reg == '0)
    `CHTE_NEXT(a_count_step, done && do_insert, total_reg == 7'($past(total_reg) + 7'd1))

endmodule

[sv/chained_hash_table_engine.sv]
`timescale 1ns / 1ps
// Hash table of BUCKETS buckets with WAYS entries each, keyed on up to 8 bytes.
// Requests enter on in_valid/in_ready with cmd (0 get, 1 set), key and value;
// one result per request leaves on out_valid/out_ready with status, value_out
// and entry_count. Registers key_bytes and value_bytes are written on the
// cfg_valid/cfg_ready port (cfg_ready is always high); the user must write
// them only while idle, as the block itself does not enforce it.
// The front end takes a new request only once the last one is pushed: it
// hashes one key byte per cycle, then, when BUCKETS is not a power of two,
// folds the hash into the remainder one byte per cycle, then waits for room
// in the queue and pushes the request. The back end reads a bucket row, then
// writes back any change once the output register is free.
// Reset clears the bucket fill counts in a sweep over all buckets; in_ready
// stays low until it finishes. Entry keys and values are not cleared.
// When out_ready is low the result is held; the back end then stalls, the
// two-entry queue fills, and in_ready drops once the front end cannot push.
module chained_hash_table_engine #(
    parameter int BUCKETS = 16,
    parameter int WAYS    = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              cmd,
    input  logic [chte_pkg::KEY_W-1:0]        key,
    input  logic [chte_pkg::VAL_W-1:0]        value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [chte_pkg::STATUS_W-1:0]     status,
    output logic [chte_pkg::VAL_W-1:0]        value_out,
    output logic [chte_pkg::COUNT_W-1:0]      entry_count,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [chte_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [chte_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import chte_pkg::*;

    localparam int BW  = $clog2(BUCKETS);
    localparam int QW  = BW + REQ_W;

    logic [CFG_DATA_W-1:0] key_bytes_reg, key_bytes_next;
    logic [CFG_DATA_W-1:0] value_bytes_reg, value_bytes_next;
    cfg_t                  cfg;

    logic                  q_push;
    logic                  q_pop;
    logic                  q_full;
    logic                  q_empty;
    logic [QW-1:0]         q_wdata;
    logic [QW-1:0]         q_rdata;
    logic                  clear_done;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        key_bytes_next   = key_bytes_reg;
        value_bytes_next = value_bytes_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_KEY_BYTES:   key_bytes_next   = cfg_data;
                REG_VALUE_BYTES: value_bytes_next = cfg_data;
                default:         key_bytes_next   = key_bytes_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_bytes_reg   <= BYTES_RESET;
            value_bytes_reg <= BYTES_RESET;
        end
        else
        begin
            key_bytes_reg   <= key_bytes_next;
            value_bytes_reg <= value_bytes_next;
        end
    end

    // Zero acts as one byte, anything above eight as eight.
    assign cfg.key_bytes   = clamp_bytes(key_bytes_reg);
    assign cfg.value_bytes = clamp_bytes(value_bytes_reg);

    // Front end: take the request, mask key and value, hash, pick the bucket.
    chte_front #(
        .BUCKETS (BUCKETS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .key        (key),
        .value      (value),
        .cfg        (cfg),
        .clear_done (clear_done),
        .q_full     (q_full),
        .push       (q_push),
        .q_wdata    (q_wdata)
    );

    // Short queue so hashing and table access stall independently.
    chte_queue #(
        .W (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    // Back end: read the bucket row, match, update the table, hold the result.
    chte_back #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_rdata     (q_rdata),
        .pop         (q_pop),
        .cfg         (cfg),
        .clear_done  (clear_done),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .value_out   (value_out),
        .entry_count (entry_count)
    );

endmodule

[sim/chained_hash_table_engine_tb.sv]
`timescale 1ns / 1ps
module chained_hash_table_engine_tb;
    import chte_pkg::*;

    localparam int BUCKETS        = 16;
    localparam int WAYS           = 4;
    localparam int SLOTS          = BUCKETS * WAYS;
    localparam int NUM_PHASES     = 8;
    localparam int RAND_PER_PHASE = 204;
    // Settling time after the last result; leave generous margin.
    localparam int SETTLE_CYCLES  = 24;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int MAX_REPORTS    = 100;
    localparam int NUM_DIRECTED   = 22;

    // One expected result per request.
    typedef struct packed {
        status_t              st;
        logic [VAL_W-1:0]     val;
        logic [COUNT_W-1:0]   cnt;
    } table_result_t;

    // One directed request; the expected result is used only when typed is set.
    typedef struct packed {
        cmd_t                 c;
        logic [KEY_W-1:0]     k;
        logic [VAL_W-1:0]     v;
        logic                 typed;
        status_t              st;
        logic [VAL_W-1:0]     vo;
        logic [COUNT_W-1:0]   cnt;
    } directed_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   cmd;
    logic [KEY_W-1:0]       key;
    logic [VAL_W-1:0]       value;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [STATUS_W-1:0]    status;
    logic [VAL_W-1:0]       value_out;
    logic [COUNT_W-1:0]     entry_count;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Shadow copy of the table, kept in request order.
    logic [CFG_DATA_W-1:0]  cfg_key_bytes   = BYTES_RESET;
    logic [CFG_DATA_W-1:0]  cfg_value_bytes = BYTES_RESET;
    int                     fill_count [BUCKETS];
    logic [KEY_W-1:0]       stored_key [SLOTS];
    logic [VAL_W-1:0]       stored_val [SLOTS];
    logic [COUNT_W-1:0]     held_entries = '0;

    table_result_t          expected_q [$];

    // Keys recently written by sets, reused so that gets hit and sets update.
    logic [KEY_W-1:0]       key_pool [64];
    int                     pool_n  = 0;
    int                     pool_wr = 0;

    int                     cycle_count = 0;
    int                     stall_left  = 0;
    int                     fail_count  = 0;
    int                     sent_count  = 0;
    int                     got_count   = 0;
    int                     status_seen [5] = '{0, 0, 0, 0, 0};

    logic [CFG_DATA_W-1:0]  key_bytes_plan   [NUM_PHASES] =
        '{4'd8, 4'd1, 4'd0, 4'd3, 4'd15, 4'd2, 4'd6, 4'd8};
    logic [CFG_DATA_W-1:0]  value_bytes_plan [NUM_PHASES] =
        '{4'd8, 4'd1, 4'd15, 4'd5, 4'd0, 4'd8, 4'd4, 4'd8};

    // With every key byte hashed, h mod 16 is the alternating sum of the key
    // bytes (65599 is -1 mod 16), ending with a plus on the top byte. So keys
    // 0, all ones, 0x10, 0x20, 0x30 and 0x80 << 56 all land in bucket 0, and
    // 0x7F lands in bucket 1. That lets the rows below fill and overflow a
    // bucket with results that can be typed in by hand.
    directed_row_t directed_rows [NUM_DIRECTED] = '{
        '{CMD_GET, 64'h0, 64'h0, 1'b1, ST_MISS, 64'h0, 7'd0},
        '{CMD_GET, '1, '1, 1'b1, ST_MISS, 64'h0, 7'd0},
        '{CMD_SET, 64'h0, '1, 1'b1, ST_INSERTED, 64'h0, 7'd1},
        '{CMD_GET, 64'h0, 64'h0, 1'b1, ST_HIT, '1, 7'd1},
        '{CMD_SET, 64'h0, 64'h0, 1'b1, ST_UPDATED, 64'h0, 7'd1},
        '{CMD_GET, 64'h0, 64'h5A5A_5A5A_5A5A_5A5A, 1'b1, ST_HIT, 64'h0, 7'd1},
        '{CMD_SET, '1, 64'h8000_0000_0000_0001, 1'b1, ST_INSERTED, 64'h0, 7'd2},
        '{CMD_GET, '1, 64'h0, 1'b1, ST_HIT, 64'h8000_0000_0000_0001, 7'd2},
        '{CMD_SET, 64'h10, 64'h0123_4567_89AB_CDEF, 1'b1, ST_INSERTED, 64'h0, 7'd3},
        '{CMD_SET, 64'h20, 64'h20, 1'b1, ST_INSERTED, 64'h0, 7'd4},
        '{CMD_SET, 64'h30, 64'h30, 1'b1, ST_FULL, 64'h0, 7'd4},
        '{CMD_GET, 64'h30, 64'h0, 1'b1, ST_MISS, 64'h0, 7'd4},
        '{CMD_SET, 64'h20, '1, 1'b1, ST_UPDATED, 64'h0, 7'd4},
        '{CMD_GET, 64'h20, 64'h0, 1'b1, ST_HIT, '1, 7'd4},
        '{CMD_SET, 64'h8000_0000_0000_0000, '1, 1'b1, ST_FULL, 64'h0, 7'd4},
        '{CMD_GET, 64'h8000_0000_0000_0000, 64'h0, 1'b1, ST_MISS, 64'h0, 7'd4},
        '{CMD_SET, 64'h7F, 64'h7F, 1'b1, ST_INSERTED, 64'h0, 7'd5},
        '{CMD_GET, 64'h7F, '1, 1'b1, ST_HIT, 64'h7F, 7'd5},
        '{CMD_SET, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b0,
          ST_HIT, 64'h0, 7'd0},
        '{CMD_GET, 64'h0123_4567_89AB_CDEF, 64'h0, 1'b0, ST_HIT, 64'h0, 7'd0},
        '{CMD_SET, 64'h00FF_00FF_00FF_00FF, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0,
          ST_HIT, 64'h0, 7'd0},
        '{CMD_GET, 64'h1111_1111_1111_117F, 64'h0, 1'b0, ST_HIT, 64'h0, 7'd0}
    };

    chained_hash_table_engine #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .key         (key),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .value_out   (value_out),
        .entry_count (entry_count),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Byte counts of 0 behave as 1, counts above 8 as 8.
    function automatic int active_bytes(input logic [CFG_DATA_W-1:0] n);
        if (n == '0)
        begin
            return 1;
        end
        return (n > 4'd8) ? 8 : int'(n);
    endfunction

    function automatic logic [KEY_W-1:0] low_bytes_mask(input logic [CFG_DATA_W-1:0] n);
        int nb;
        nb = active_bytes(n);
        if (nb == 8)
        begin
            return '1;
        end
        return (64'd1 << (8 * nb)) - 64'd1;
    endfunction

    // sdbm over the low bytes, lowest first, each byte taken as signed:
    // h = h * 65599 + byte, wrapping at 64 bits.
    function automatic logic [KEY_W-1:0] sdbm_of(input logic [KEY_W-1:0] k, input int nb);
        logic [KEY_W-1:0] h;
        logic [KEY_W-1:0] b;
        h = '0;
        for (int i = 0; i < nb; i++)
        begin
            b = {{(KEY_W - 8){k[8 * i + 7]}}, k[8 * i +: 8]};
            h = h * 64'd65599 + b;
        end
        return h;
    endfunction

    // Apply one request to the shadow table and return the result it must give.
    function automatic table_result_t apply_table_op(input cmd_t c,
                                                     input logic [KEY_W-1:0] k,
                                                     input logic [VAL_W-1:0] v);
        table_result_t r;
        logic [KEY_W-1:0] km;
        logic [VAL_W-1:0] vm;
        int bkt;
        int base;
        int fill;
        int hit_slot;
        km       = low_bytes_mask(cfg_key_bytes);
        vm       = low_bytes_mask(cfg_value_bytes);
        bkt      = int'(sdbm_of(k, active_bytes(cfg_key_bytes)) % 64'(BUCKETS));
        base     = bkt * WAYS;
        fill     = fill_count[bkt];
        hit_slot = -1;
        r.val    = '0;
        // Take the first filled entry that matches on the current key bytes.
        for (int i = 0; i < fill; i++)
        begin
            if (hit_slot < 0 && ((stored_key[base + i] ^ k) & km) == '0)
            begin
                hit_slot = base + i;
            end
        end
        if (c == CMD_GET)
        begin
            if (hit_slot >= 0)
            begin
                r.st  = ST_HIT;
                r.val = stored_val[hit_slot] & vm;
            end
            else
            begin
                r.st = ST_MISS;
            end
        end
        else if (hit_slot >= 0)
        begin
            stored_val[hit_slot] = v & vm;
            r.st = ST_UPDATED;
        end
        else if (fill >= WAYS)
        begin
            r.st = ST_FULL;
        end
        else
        begin
            stored_key[base + fill] = k & km;
            stored_val[base + fill] = v & vm;
            fill_count[bkt]         = fill + 1;
            held_entries            = held_entries + 1'b1;
            r.st = ST_INSERTED;
        end
        r.cnt = held_entries;
        return r;
    endfunction

    // Mix pool keys (hits and updates, with the ignored upper bytes scrambled),
    // keys built from corner bytes (sign boundary, crowded buckets) and fresh
    // random keys.
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] m;
        logic [7:0] corner [4];
        int sel;
        corner = '{8'h00, 8'h7F, 8'h80, 8'hFF};
        k      = {$urandom, $urandom};
        sel    = $urandom_range(9);
        if (sel < 4 && pool_n > 0)
        begin
            m = low_bytes_mask(cfg_key_bytes);
            k = (key_pool[$urandom_range(pool_n - 1)] & m) | (k & ~m);
        end
        else if (sel < 6)
        begin
            for (int i = 0; i < 8; i++)
            begin
                k[8 * i +: 8] = corner[$urandom_range(3)];
            end
        end
        return k;
    endfunction

    // Hold one request until it is taken, then queue its expected result.
    task automatic issue(input cmd_t c, input logic [KEY_W-1:0] k,
                         input logic [VAL_W-1:0] v, input logic typed,
                         input table_result_t want);
        table_result_t pred;
        in_valid <= 1'b1;
        cmd      <= c;
        key      <= k;
        value    <= v;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        pred = apply_table_op(c, k, v);
        expected_q.push_back(typed ? want : pred);
        sent_count++;
        if (c == CMD_SET)
        begin
            key_pool[pool_wr] = k;
            pool_wr = (pool_wr + 1) % 64;
            if (pool_n < 64)
            begin
                pool_n++;
            end
        end
    endtask

    task automatic idle_for(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        if (idx == REG_KEY_BYTES)
        begin
            cfg_key_bytes = d;
        end
        else
        begin
            cfg_value_bytes = d;
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Send random requests in bursts of random length with random gaps.
    task automatic run_random(input int n);
        int burst;
        int sel;
        cmd_t c;
        logic [VAL_W-1:0] v;
        burst = 0;
        for (int i = 0; i < n; i++)
        begin
            if (burst == 0)
            begin
                if ($urandom_range(3) != 0)
                begin
                    idle_for($urandom_range(12, 1));
                end
                burst = ($urandom_range(7) == 0) ? 60 : $urandom_range(24, 1);
            end
            burst--;
            c   = ($urandom_range(1) != 0) ? CMD_SET : CMD_GET;
            sel = $urandom_range(7);
            v   = (sel == 0) ? '0 : (sel == 1) ? '1 : {$urandom, $urandom};
            issue(c, pick_key(), v, 1'b0, '0);
        end
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] exp_v,
                                   input logic [63:0] act_v);
        // Keep the log readable when the block is badly off.
        if (fail_count < MAX_REPORTS)
        begin
            $error("%s mismatch on result %0d: expected 0x%0h, got 0x%0h",
                   field, got_count, exp_v, act_v);
        end
        fail_count++;
    endtask

    // Receiver: cycle through always ready, random drops, long stalls and an
    // every-other-cycle pattern, switching on bits 9:8 of the cycle count.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else
        begin
            case (cycle_count[9:8])
                2'd0: out_ready <= 1'b1;
                2'd1: out_ready <= ($urandom_range(2) != 0);
                2'd2:
                begin
                    out_ready <= 1'b1;
                    if ($urandom_range(15) == 0)
                    begin
                        stall_left <= $urandom_range(24, 4);
                    end
                end
                default: out_ready <= cycle_count[0];
            endcase
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        table_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                if (fail_count < MAX_REPORTS)
                begin
                    $error("result with no request outstanding: status %0d", status);
                end
                fail_count++;
            end
            else
            begin
                exp_r = expected_q.pop_front();
                got_count++;
                status_seen[exp_r.st]++;
                if (status !== exp_r.st)
                begin
                    report_mismatch("status", 64'(exp_r.st), 64'(status));
                end
                if (value_out !== exp_r.val)
                begin
                    report_mismatch("value_out", exp_r.val, value_out);
                end
                if (entry_count !== exp_r.cnt)
                begin
                    report_mismatch("entry_count", 64'(exp_r.cnt), 64'(entry_count));
                end
            end
        end
    end

    // Watchdog: drop the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d results outstanding",
                   cycle_count, expected_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        table_result_t want;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        cmd       = 1'b0;
        key       = '0;
        value     = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        foreach (fill_count[b])
        begin
            fill_count[b] = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset register values; in_ready holds the
        // first request off until the bucket sweep after reset is done.
        foreach (directed_rows[i])
        begin
            want = '{directed_rows[i].st, directed_rows[i].vo, directed_rows[i].cnt};
            issue(directed_rows[i].c, directed_rows[i].k, directed_rows[i].v,
                  directed_rows[i].typed, want);
        end

        // Random phases. Each new register setting is written only once the
        // block has drained, so the sender also pauses fully at every phase edge.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p != 0)
            begin
                drain();
                write_reg(REG_KEY_BYTES, key_bytes_plan[p]);
                write_reg(REG_VALUE_BYTES, value_bytes_plan[p]);
            end
            run_random(RAND_PER_PHASE);
        end
        drain();

        $display("Covered %0d requests over %0d register settings: %0d hit, %0d miss,",
                 sent_count, NUM_PHASES, status_seen[ST_HIT], status_seen[ST_MISS]);
        $display("%0d updated, %0d inserted, %0d bucket full; table ended with %0d of %0d.",
                 status_seen[ST_UPDATED], status_seen[ST_INSERTED], status_seen[ST_FULL],
                 held_entries, SLOTS);
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/chte_pkg.sv
sv/chte_queue.sv
sv/chte_front.sv
sv/chte_back.sv
sv/chained_hash_table_engine.sv
sim/chained_hash_table_engine_tb.sv
